@@ rtl/wcp_pkg.sv @@
// ----------------------------------------------------------------------------
// wcp_pkg
// Types and constants shared by the RIFF/WAVE chunk header parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wcp_pkg;

  // Leading body bytes extracted from the known chunk kinds
  localparam int unsigned FMT_BODY_BYTES  = 16;
  localparam int unsigned FACT_BODY_BYTES = 4;

  // Chunk labels as they assemble, first byte in the low bits
  localparam logic [31:0] LABEL_FMT  = 32'h2074_6D66;
  localparam logic [31:0] LABEL_FACT = 32'h7463_6166;
  localparam logic [31:0] LABEL_DATA = 32'h6174_6164;

  // Printable range for label bytes
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7A;

  // Port widths
  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = 224;
  localparam int unsigned M_TUSER_W = 5;

  typedef enum logic [2:0] {
    ST_DONE       = 3'd0,
    ST_DATA       = 3'd1,
    ST_BAD_LABEL  = 3'd2,
    ST_BAD_LENGTH = 3'd3,
    ST_TRUNCATED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_FMT     = 2'd0,
    KIND_FACT    = 2'd1,
    KIND_DATA    = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_t;

  // One classified input byte as it travels from front to back
  typedef struct packed {
    logic       last;
    logic       printable;
    logic [7:0] data;
  } token_t;

  // One parser result
  typedef struct packed {
    status_t     status;
    kind_t       kind;
    logic [31:0] label;
    logic [31:0] length;
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [31:0] frame_rate;
    logic [31:0] data_rate;
    logic [15:0] block_align;
    logic [15:0] sample_bits;
    logic [31:0] sample_count;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/wcp_front.sv @@
// ----------------------------------------------------------------------------
// wcp_front
// Input stage: registers each stream byte and tags it as printable or not.
// ----------------------------------------------------------------------------
`default_nettype none

module wcp_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [wcp_pkg::S_TDATA_W-1:0]   s_tdata,
  input  wire logic                            s_tlast,
  output logic                                 tok_valid,
  input  wire logic                            tok_ready,
  output wcp_pkg::token_t                      tok
);
  import wcp_pkg::*;

  logic take;

  assign s_tready = !tok_valid || tok_ready;
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (s_tready) begin
      tok_valid <= s_tvalid;
    end
    if (take) begin
      tok.last      <= s_tlast;
      tok.data      <= s_tdata;
      tok.printable <= (s_tdata >= PRINT_LO) && (s_tdata <= PRINT_HI);
    end
  end

endmodule

`default_nettype wire

@@ rtl/wcp_queue.sv @@
// ----------------------------------------------------------------------------
// wcp_queue
// Short FIFO of classified bytes between the front and back stages.
// ----------------------------------------------------------------------------
`default_nettype none

module wcp_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire wcp_pkg::token_t  in_tok,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output wcp_pkg::token_t       out_tok
);
  import wcp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  token_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;

  assign in_ready  = count != CNT_W'(DEPTH);
  assign out_valid = count != '0;
  assign out_tok   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= in_tok;
    end
  end

endmodule

`default_nettype wire

@@ rtl/wcp_back.sv @@
// ----------------------------------------------------------------------------
// wcp_back
// Chunk walker: assembles label, length and body bytes and issues results.
// ----------------------------------------------------------------------------
`default_nettype none

module wcp_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             tok_valid,
  output logic                  tok_ready,
  input  wire wcp_pkg::token_t  tok,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output wcp_pkg::result_t      res
);
  import wcp_pkg::*;

  typedef enum logic [1:0] {
    PH_LABEL,
    PH_LENGTH,
    PH_BODY,
    PH_SKIP
  } phase_t;

  phase_t      phase;
  logic [31:0] cnt;
  logic [31:0] label;
  logic [31:0] length;
  logic [63:0] body0;
  logic [63:0] body1;
  kind_t       kind;
  logic        label_bad;
  logic        halted;

  logic        take;
  logic [31:0] label_full;
  logic [31:0] length_full;
  logic [63:0] body0_full;
  logic [63:0] body1_full;
  kind_t       kind_new;
  kind_t       end_kind;
  logic [31:0] need;
  logic [3:0]  need_last;
  logic        length_bad;
  logic [31:0] cnt_dec;

  function automatic result_t make_res(status_t st, kind_t k, logic [31:0] lab,
                                       logic [31:0] len, logic [63:0] b0,
                                       logic [63:0] b1, logic fields);
    result_t r;
    r        = '0;
    r.status = st;
    r.kind   = k;
    r.label  = lab;
    r.length = len;
    if (fields && k == KIND_FMT) begin
      r.format_tag    = b0[15:0];
      r.channel_count = b0[31:16];
      r.frame_rate    = b0[63:32];
      r.data_rate     = b1[31:0];
      r.block_align   = b1[47:32];
      r.sample_bits   = b1[63:48];
    end
    if (fields && k == KIND_FACT) begin
      r.sample_count = b0[31:0];
    end
    return r;
  endfunction

  assign tok_ready = !res_valid || res_ready;
  assign take      = tok_valid && tok_ready;

  always_comb begin
    label_full                      = label;
    label_full[8*cnt[1:0] +: 8]     = tok.data;
    length_full                     = length;
    length_full[8*cnt[1:0] +: 8]    = tok.data;
    body0_full                      = body0;
    body1_full                      = body1;
    if (cnt[3]) begin
      body1_full[8*cnt[2:0] +: 8] = tok.data;
    end else begin
      body0_full[8*cnt[2:0] +: 8] = tok.data;
    end
    if (label_full == LABEL_FMT) begin
      kind_new = KIND_FMT;
    end else if (label_full == LABEL_FACT) begin
      kind_new = KIND_FACT;
    end else if (label_full == LABEL_DATA) begin
      kind_new = KIND_DATA;
    end else begin
      kind_new = KIND_UNKNOWN;
    end
    end_kind   = (phase == PH_LABEL) ? KIND_UNKNOWN : kind;
    need       = (kind == KIND_FMT) ? 32'(FMT_BODY_BYTES) : 32'(FACT_BODY_BYTES);
    need_last  = 4'(need - 32'd1);
    length_bad = length_full[31] || (length_full < need);
    cnt_dec    = (cnt == '0) ? '0 : cnt - 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_LABEL;
      cnt       <= '0;
      label     <= '0;
      length    <= '0;
      label_bad <= 1'b0;
      halted    <= 1'b0;
      kind      <= KIND_UNKNOWN;
      res_valid <= 1'b0;
    end else begin
      if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (take && !halted) begin
        if (tok.last) begin
          halted    <= 1'b1;
          res_valid <= 1'b1;
          res       <= make_res(ST_TRUNCATED, end_kind, label, length,
                                body0, body1, 1'b0);
        end else begin
          case (phase)
            PH_LABEL: begin
              label <= label_full;
              cnt   <= cnt + 32'd1;
              if (cnt[1:0] == 2'd3) begin
                if (label_bad || !tok.printable) begin
                  halted    <= 1'b1;
                  res_valid <= 1'b1;
                  res       <= make_res(ST_BAD_LABEL, KIND_UNKNOWN, label_full,
                                        length, body0, body1, 1'b0);
                end else begin
                  phase <= PH_LENGTH;
                  cnt   <= '0;
                  kind  <= kind_new;
                  body0 <= '0;
                  body1 <= '0;
                end
              end else begin
                label_bad <= label_bad || !tok.printable;
              end
            end
            PH_LENGTH: begin
              length <= length_full;
              cnt    <= cnt + 32'd1;
              if (cnt[1:0] == 2'd3) begin
                if (kind == KIND_DATA) begin
                  halted    <= 1'b1;
                  res_valid <= 1'b1;
                  res       <= make_res(ST_DATA, KIND_DATA, label, length_full,
                                        body0, body1, 1'b0);
                end else if (kind == KIND_UNKNOWN) begin
                  if (length_full == '0) begin
                    res_valid <= 1'b1;
                    res       <= make_res(ST_DONE, KIND_UNKNOWN, label, length_full,
                                          body0, body1, 1'b0);
                    phase     <= PH_LABEL;
                    cnt       <= '0;
                    label     <= '0;
                    length    <= '0;
                    label_bad <= 1'b0;
                  end else begin
                    phase <= PH_SKIP;
                    cnt   <= length_full;
                  end
                end else if (length_bad) begin
                  halted    <= 1'b1;
                  res_valid <= 1'b1;
                  res       <= make_res(ST_BAD_LENGTH, kind, label, length_full,
                                        body0, body1, 1'b0);
                end else begin
                  phase <= PH_BODY;
                  cnt   <= '0;
                end
              end
            end
            PH_BODY: begin
              body0 <= body0_full;
              body1 <= body1_full;
              cnt   <= cnt + 32'd1;
              if (cnt[3:0] == need_last) begin
                if (length > need) begin
                  phase <= PH_SKIP;
                  cnt   <= length - need;
                end else begin
                  res_valid <= 1'b1;
                  res       <= make_res(ST_DONE, kind, label, length,
                                        body0_full, body1_full, 1'b1);
                  phase     <= PH_LABEL;
                  cnt       <= '0;
                  label     <= '0;
                  length    <= '0;
                  label_bad <= 1'b0;
                end
              end
            end
            default: begin
              cnt <= cnt_dec;
              if (cnt_dec == '0) begin
                res_valid <= 1'b1;
                res       <= make_res(ST_DONE, kind, label, length,
                                      body0, body1, 1'b1);
                phase     <= PH_LABEL;
                label     <= '0;
                length    <= '0;
                label_bad <= 1'b0;
              end
            end
          endcase
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/wav_chunk_header_parser.sv @@
// ----------------------------------------------------------------------------
// wav_chunk_header_parser
// Streams a WAV file one byte per transfer and reports its RIFF chunk headers.
// ----------------------------------------------------------------------------
// The block takes one file byte per transfer on the slave side (s_tlast high
// means the file ended and the transfer carries no byte) and walks the RIFF
// chunks: a four-byte printable label (each byte 0x20..0x7A) and a
// little-endian 32-bit length. A 'fmt ' chunk yields its first 16 body bytes as
// six fields, a 'fact' chunk its first four as a sample count; further body
// bytes and unknown chunks are skipped. One result transfer leaves on the master
// side per finished chunk. A 'data' header, a bad label, a bad length or an
// early end of file yields a final result and halts the block: from then on
// every input transfer is taken and dropped until rst. The block takes one byte
// per clock cycle while no result waits on the master side; m_tvalid rises
// once the byte that completes a result has passed the input register and the
// queue and the result register has loaded, and a two-entry queue between the
// byte classifier and the walker lets either side stall alone.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_chunk_header_parser #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // slave side
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [wcp_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
  input  wire logic                           s_tlast,   // stream_end
  // master side
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // [31:0] chunk_label, [63:32] chunk_length, [79:64] format_tag,
  // [95:80] channel_count, [127:96] frame_rate, [159:128] data_rate,
  // [175:160] block_align, [191:176] sample_bits, [223:192] sample_count
  output logic [wcp_pkg::M_TDATA_W-1:0]       m_tdata,
  output logic [wcp_pkg::M_TUSER_W-1:0]       m_tuser    // [2:0] status, [4:3] chunk_kind
);
  import wcp_pkg::*;

  logic    f_valid;
  logic    f_ready;
  token_t  f_tok;
  logic    q_valid;
  logic    q_ready;
  token_t  q_tok;
  result_t res;

  // Classify: register each byte and flag whether it is printable
  wcp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .tok_valid (f_valid),
    .tok_ready (f_ready),
    .tok       (f_tok)
  );

  // Decouple: hold classified bytes while the walker waits on the master side
  wcp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_tok    (f_tok),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_tok   (q_tok)
  );

  // Walk the chunks and hold each result until the master side takes it
  wcp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (q_valid),
    .tok_ready (q_ready),
    .tok       (q_tok),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tuser = {res.kind, res.status};
  assign m_tdata = {res.sample_count, res.sample_bits, res.block_align,
                    res.data_rate, res.frame_rate, res.channel_count,
                    res.format_tag, res.length, res.label};

`ifndef SYNTHESIS
  // fmt body fields stay zero unless a fmt chunk finished cleanly
  a_fmt_fields_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !(m_tuser[2:0] == ST_DONE && m_tuser[4:3] == KIND_FMT)
      |-> m_tdata[191:64] == '0)
    else $error("fmt fields set outside a finished fmt chunk");

  // sample count stays zero unless a fact chunk finished cleanly
  a_fact_field_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !(m_tuser[2:0] == ST_DONE && m_tuser[4:3] == KIND_FACT)
      |-> m_tdata[223:192] == '0)
    else $error("sample count set outside a finished fact chunk");

  // a bad label is reported as an unknown chunk with no length
  a_bad_label_shape : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2:0] == ST_BAD_LABEL
      |-> m_tuser[4:3] == KIND_UNKNOWN && m_tdata[63:32] == '0)
    else $error("bad label result carries a kind or a length");

  // a data header result always names the data kind
  a_data_kind : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2:0] == ST_DATA |-> m_tuser[4:3] == KIND_DATA)
    else $error("data header result with wrong kind");
`endif

endmodule

`default_nettype wire
